>>> sv/sprd_pkg.sv
// ----------------------------------------------------------------------------
// sprd_pkg: shared types and constants
// Op codes, register indexes, limits and small helpers of the strobed row
// driver with spinner emulation.
// ----------------------------------------------------------------------------
package sprd_pkg;

   localparam int RowCount    = 4;
   localparam int PhaseStates = 3;

   typedef logic [2:0]         op_type;
   typedef logic [5:0]         lines_type;
   typedef logic [3:0]         strobe_type;
   typedef logic [1:0]         phase_type;
   typedef logic signed [15:0] count_type;
   typedef logic [23:0]        ticks_type;
   typedef logic [2:0]         csr_index_type;

   localparam op_type OP_TICK       = 3'd0;
   localparam op_type OP_MOTION     = 3'd1;
   localparam op_type OP_ROW_LOAD   = 3'd2;
   localparam op_type OP_STROBE     = 3'd3;
   localparam op_type OP_DISCONNECT = 3'd4;

   localparam csr_index_type CSR_SPINNER_MODE = 3'd0;
   localparam csr_index_type CSR_STEP_DIVISOR = 3'd1;
   localparam csr_index_type CSR_DIR_INVERT   = 3'd2;
   localparam csr_index_type CSR_INT_SCALE    = 3'd3;

   localparam logic [7:0]  DIVISOR_RESET = 8'd4;
   localparam logic [15:0] SCALE_RESET   = 16'd3000;
   localparam lines_type   LINES_RELEASED = 6'h3F;
   localparam strobe_type  STROBE_IDLE    = 4'hF;
   localparam ticks_type   TICK_MAX       = 24'hFFFFFF;
   localparam count_type   COUNT_MAX      = 16'sd32767;
   localparam count_type   COUNT_MIN      = -16'sd32767;

   localparam phase_type PHASE_LOW   = 2'd0;
   localparam phase_type PHASE_LINE4 = 2'd1;
   localparam phase_type PHASE_LINE5 = 2'd2;

   // saturate to +/-32767
   function automatic count_type sat_count(input logic signed [17:0] v);
      count_type r;
      if (v > 18'sd32767) begin
         r = COUNT_MAX;
      end else if (v < -18'sd32767) begin
         r = COUNT_MIN;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // levels of lines 5:4 for a phase position
   function automatic logic [1:0] phase_bits(input phase_type p);
      logic [1:0] r;
      case (p)
         PHASE_LINE4: r = 2'b01;
         PHASE_LINE5: r = 2'b10;
         default:     r = 2'b00;
      endcase
      return r;
   endfunction

endpackage

>>> sv/spinner_phase_and_strobed_row_driver_top.sv
// ----------------------------------------------------------------------------
// spinner_phase_and_strobed_row_driver_top
// Strobed six-line row driver with rotary spinner phase emulation.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns exactly one result word for each, in the
// cycle after acceptance, from a single output register; the input stalls only
// while that register holds a word the output side is stalling. Each result
// shows the line levels, phase and step queue after the word is applied.
// Configuration writes are taken at any edge with csr_write_en high; indexes
// above 3 are ignored. A disconnect word also clears spinner mode.
// ----------------------------------------------------------------------------
module spinner_phase_and_strobed_row_driver_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sprd_pkg::op_type          req_op,
   input  logic signed [15:0]        req_motion_delta,
   input  logic [1:0]                req_row_select,
   input  sprd_pkg::lines_type       req_row_lines,
   input  sprd_pkg::strobe_type      req_strobe_lines,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sprd_pkg::lines_type       rsp_port_lines,
   output sprd_pkg::phase_type       rsp_phase_index,
   output sprd_pkg::count_type       rsp_pending_steps,
   input  logic                      csr_write_en,
   input  sprd_pkg::csr_index_type   csr_index,
   input  logic [15:0]               csr_wdata
);

   logic                 mode_ff, mode_in;
   logic [7:0]           divisor_ff, divisor_in;
   logic                 invert_ff, invert_in;
   logic [15:0]          scale_ff, scale_in;

   sprd_pkg::lines_type  rows_ff [sprd_pkg::RowCount];
   sprd_pkg::lines_type  rows_in [sprd_pkg::RowCount];
   sprd_pkg::strobe_type strobe_ff, strobe_in;
   sprd_pkg::phase_type  phase_ff, phase_in;
   sprd_pkg::count_type  queue_ff, queue_in;
   sprd_pkg::count_type  accum_ff, accum_in;
   sprd_pkg::ticks_type  elapsed_ff, elapsed_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   sprd_pkg::lines_type  rsp_lines_ff, rsp_lines_in;
   sprd_pkg::phase_type  rsp_phase_ff, rsp_phase_in;
   sprd_pkg::count_type  rsp_queue_ff, rsp_queue_in;

   logic                 accept;
   sprd_pkg::ticks_type  interval;
   sprd_pkg::ticks_type  elapsed_inc;
   logic signed [16:0]   d_ext;
   logic signed [16:0]   d_sel;
   sprd_pkg::count_type  d_sat;
   sprd_pkg::count_type  accum_sum;
   logic signed [16:0]   div_pos;
   logic signed [16:0]   accum_ext;
   logic                 step_up;
   logic                 step_dn;
   sprd_pkg::count_type  q_base;
   sprd_pkg::lines_type  row_lines;
   sprd_pkg::strobe_type active;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign interval    = 24'(divisor_ff) * 24'(scale_ff);
   assign elapsed_inc = (elapsed_ff == sprd_pkg::TICK_MAX) ? elapsed_ff : elapsed_ff + 24'd1;

   // motion path
   assign d_ext     = {req_motion_delta[15], req_motion_delta};
   assign d_sel     = (invert_ff && mode_ff) ? -d_ext : d_ext;
   assign d_sat     = sprd_pkg::sat_count({d_sel[16], d_sel});
   assign accum_sum = sprd_pkg::sat_count({{2{accum_ff[15]}}, accum_ff} +
                                          {{2{d_sat[15]}}, d_sat});
   assign accum_ext = {accum_sum[15], accum_sum};
   assign div_pos   = {9'd0, divisor_ff};
   assign step_up   = accum_ext >= div_pos;
   assign step_dn   = !step_up && (accum_ext <= -div_pos);

   always_comb begin
      mode_in    = mode_ff;
      divisor_in = divisor_ff;
      invert_in  = invert_ff;
      scale_in   = scale_ff;
      rows_in    = rows_ff;
      strobe_in  = strobe_ff;
      phase_in   = phase_ff;
      queue_in   = queue_ff;
      accum_in   = accum_ff;
      elapsed_in = elapsed_ff;
      q_base     = queue_ff;

      if (accept) begin
         case (req_op)
            sprd_pkg::OP_TICK: begin
               elapsed_in = elapsed_inc;
               if (mode_ff && (queue_ff != 16'sd0) && (interval != 24'd0) &&
                   (elapsed_inc >= interval)) begin
                  elapsed_in = '0;
                  if (queue_ff > 16'sd0) begin
                     queue_in = queue_ff - 16'sd1;
                     phase_in = (phase_ff == sprd_pkg::PHASE_LOW) ? sprd_pkg::PHASE_LINE5 :
                                phase_ff - 2'd1;
                  end else begin
                     queue_in = queue_ff + 16'sd1;
                     phase_in = (phase_ff == sprd_pkg::PHASE_LINE5) ? sprd_pkg::PHASE_LOW :
                                phase_ff + 2'd1;
                  end
               end
            end
            sprd_pkg::OP_MOTION: begin
               if (d_sat == 16'sd0) begin
                  accum_in = '0;
               end else if (step_up) begin
                  accum_in = '0;
                  q_base   = (queue_ff < 16'sd0) ? 16'sd0 : queue_ff;
                  queue_in = (q_base == sprd_pkg::COUNT_MAX) ? q_base : q_base + 16'sd1;
               end else if (step_dn) begin
                  accum_in = '0;
                  q_base   = (queue_ff > 16'sd0) ? 16'sd0 : queue_ff;
                  queue_in = (q_base == sprd_pkg::COUNT_MIN) ? q_base : q_base - 16'sd1;
               end else begin
                  accum_in = accum_sum;
               end
            end
            sprd_pkg::OP_ROW_LOAD: begin
               rows_in[req_row_select] = req_row_lines;
            end
            sprd_pkg::OP_STROBE: begin
               strobe_in = req_strobe_lines;
            end
            sprd_pkg::OP_DISCONNECT: begin
               for (int r = 0; r < sprd_pkg::RowCount; r++) begin
                  rows_in[r] = sprd_pkg::LINES_RELEASED;
               end
               phase_in = sprd_pkg::PHASE_LOW;
               queue_in = '0;
               mode_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (csr_write_en) begin
         case (csr_index)
            sprd_pkg::CSR_SPINNER_MODE: mode_in    = csr_wdata[0];
            sprd_pkg::CSR_STEP_DIVISOR: divisor_in = csr_wdata[7:0];
            sprd_pkg::CSR_DIR_INVERT:   invert_in  = csr_wdata[0];
            sprd_pkg::CSR_INT_SCALE:    scale_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // result from the updated state, lowest active strobe wins
   assign active = ~strobe_in;

   always_comb begin
      if (active[0]) begin
         row_lines = rows_in[0];
      end else if (active[1]) begin
         row_lines = rows_in[1];
      end else if (active[2]) begin
         row_lines = rows_in[2];
      end else if (active[3]) begin
         row_lines = rows_in[3];
      end else begin
         row_lines = sprd_pkg::LINES_RELEASED;
      end
      rsp_lines_in = mode_in ? {sprd_pkg::phase_bits(phase_in), row_lines[3:0]} : row_lines;
      rsp_phase_in = phase_in;
      rsp_queue_in = queue_in;
      rsp_valid_in = rsp_valid_ff;
      if (!req_stall) begin
         rsp_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         divisor_ff   <= sprd_pkg::DIVISOR_RESET;
         invert_ff    <= 1'b0;
         scale_ff     <= sprd_pkg::SCALE_RESET;
         for (int r = 0; r < sprd_pkg::RowCount; r++) begin
            rows_ff[r] <= sprd_pkg::LINES_RELEASED;
         end
         strobe_ff    <= sprd_pkg::STROBE_IDLE;
         phase_ff     <= sprd_pkg::PHASE_LOW;
         queue_ff     <= '0;
         accum_ff     <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         divisor_ff   <= divisor_in;
         invert_ff    <= invert_in;
         scale_ff     <= scale_in;
         rows_ff      <= rows_in;
         strobe_ff    <= strobe_in;
         phase_ff     <= phase_in;
         queue_ff     <= queue_in;
         accum_ff     <= accum_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_lines_ff <= rsp_lines_in;
         rsp_phase_ff <= rsp_phase_in;
         rsp_queue_ff <= rsp_queue_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_port_lines    = rsp_lines_ff;
   assign rsp_phase_index   = rsp_phase_ff;
   assign rsp_pending_steps = rsp_queue_ff;

endmodule

>>> sv/sprd_checker.sv
// ----------------------------------------------------------------------------
// sprd_checker
// Port-level checks for the strobed row driver, bound to the top level.
// ----------------------------------------------------------------------------
module sprd_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input sprd_pkg::op_type        req_op,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input sprd_pkg::lines_type     rsp_port_lines,
   input sprd_pkg::phase_type     rsp_phase_index,
   input sprd_pkg::count_type     rsp_pending_steps
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_port_lines) &&
      $stable(rsp_phase_index) && $stable(rsp_pending_steps))
      else $error("stalled result word changed");

   // every accepted word yields a result next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no result");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase_index < 2'(sprd_pkg::PhaseStates))
      else $error("phase out of range");

   a_queue_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pending_steps != -16'sd32768)
      else $error("step queue past saturation");

   // disconnect clears phase and queue, drops spinner lines
   a_disconnect: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == sprd_pkg::OP_DISCONNECT |=>
      rsp_phase_index == sprd_pkg::PHASE_LOW && rsp_pending_steps == 16'sd0 &&
      rsp_port_lines == sprd_pkg::LINES_RELEASED)
      else $error("disconnect did not clear state");

endmodule

bind spinner_phase_and_strobed_row_driver_top sprd_checker u_sprd_checker (.*);
